// ===== design/ff4_pkg.sv =====
// ----------------------------------------------------------------------------
// ff4_pkg
// Shared types and codes for the four-connected flood fill block.
// ----------------------------------------------------------------------------
package ff4_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ROWS = 1'd0,
    REG_COLS = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_WAIT,
    ST_CLEAR,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_WAIT,
    ST_NB_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [12:0] region_count;
    logic        status;
  } out_word_t;

endpackage

// ===== design/ff4_ram.sv =====
// ----------------------------------------------------------------------------
// ff4_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ff4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/four_connected_flood_fill.sv =====
// ----------------------------------------------------------------------------
// four_connected_flood_fill
// Image store with pixel write, pixel read and four-connected flood fill.
// ----------------------------------------------------------------------------
//  channel  | dir | payload             | accept
//  in       | in  | ff4_pkg::in_word_t  | in_valid & in_ready
//  out      | out | ff4_pkg::out_word_t | out_valid & out_ready
//  cfg      | in  | cfg_index, cfg_data | cfg_valid & cfg_ready
//
// Write and read: the accepted input word passes through the seed read and seed
// wait states to the final state, where the result word is registered; a coordinate
// outside the image or an unused command goes straight to the final state.
// A fill sweeps the visited map first, one entry a cycle, then pops each region
// pixel, recolors it and reads its in-image neighbors; every memory has one port.
// Reset is synchronous; the visited map needs no clearing pass after reset
// since every fill clears it. A result waiting in the output register does not
// hold the input; the block stops in its final state only when a second result
// is ready before the first word is taken.
module four_connected_flood_fill #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int COLOR_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ff4_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ff4_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import ff4_pkg::*;

  localparam int NPIX = MAX_ROWS * MAX_COLS;
  localparam int AW   = $clog2(NPIX);
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW   = RW + CW;
  localparam int SPW  = $clog2(NPIX + 1);

  state_t state, state_next;

  logic [6:0] rows_in_use, cols_in_use;
  logic [10:0] eff_rows, eff_cols;

  logic [RW-1:0] cur_r, nb_r;
  logic [CW-1:0] cur_c, nb_c;
  logic [COLOR_BITS-1:0] old_color, fill_color;
  logic [SPW-1:0] sp;
  logic [12:0] count;
  logic [1:0] dir;
  logic [AW-1:0] clr_addr;
  logic nb_ok;
  out_word_t res, acc;

  logic [1:0] in_cmd_q;
  logic [RW-1:0] q_r;
  logic [CW-1:0] q_c;
  logic [7:0] q_val;
  logic nb_hit;
  logic [AW-1:0] nb_idx;
  logic nb_probe;
  logic nb_ok_q;
  logic in_range;
  logic accept;

  // memory ports
  logic pix_we, vis_we, stk_we;
  logic [AW-1:0] pix_addr, vis_addr, stk_addr;
  logic [COLOR_BITS-1:0] pix_wdata, pix_rdata;
  logic vis_wdata, vis_rdata;
  logic [SW-1:0] stk_wdata, stk_rdata;

  ff4_ram #(.WIDTH(COLOR_BITS), .DEPTH(NPIX)) u_pix (
    .clk, .we(pix_we), .addr(pix_addr), .wdata(pix_wdata), .rdata(pix_rdata));
  ff4_ram #(.WIDTH(1), .DEPTH(NPIX)) u_vis (
    .clk, .we(vis_we), .addr(vis_addr), .wdata(vis_wdata), .rdata(vis_rdata));
  ff4_ram #(.WIDTH(SW), .DEPTH(NPIX)) u_stk (
    .clk, .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata));

  function automatic logic [AW-1:0] pix_idx(input logic [RW-1:0] r,
                                             input logic [CW-1:0] c);
    logic [AW+RW+CW-1:0] p;
    p = (AW+RW+CW)'(r) * (AW+RW+CW)'(MAX_COLS) + (AW+RW+CW)'(c);
    return p[AW-1:0];
  endfunction

  assign eff_rows = (11'(rows_in_use) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_in_use);
  assign eff_cols = (11'(cols_in_use) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_in_use);

  assign in_range = (11'(in_data.row) < eff_rows) && (11'(in_data.col) < eff_cols);

  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE) && !in_valid;
  assign out_data   = res;
  assign fill_color = COLOR_BITS'(q_val);

  // Neighbor coordinate for the current direction: left, right, up, down.
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (dir)
      2'd0: begin
        nb_c  = cur_c - CW'(1);
        nb_ok = (cur_c != '0);
      end
      2'd1: begin
        nb_c  = cur_c + CW'(1);
        nb_ok = (11'(cur_c) + 11'd1 < eff_cols);
      end
      2'd2: begin
        nb_r  = cur_r - RW'(1);
        nb_ok = (cur_r != '0);
      end
      default: begin
        nb_r  = cur_r + RW'(1);
        nb_ok = (11'(cur_r) + 11'd1 < eff_rows);
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_range && in_data.cmd != CMD_NONE) state_next = ST_SEED_RD;
          else state_next = ST_DONE;
        end
      end
      ST_SEED_RD:   state_next = ST_SEED_WAIT;
      ST_SEED_WAIT: begin
        if (cmd_t'(in_cmd_q) == CMD_FILL) state_next = ST_CLEAR;
        else state_next = ST_DONE;
      end
      ST_CLEAR:    if (clr_addr == AW'(NPIX - 1)) state_next = ST_POP;
      ST_POP: begin
        if (sp == '0) state_next = ST_DONE;
        else state_next = ST_POP_WAIT;
      end
      ST_POP_WAIT: state_next = ST_NB_RD;
      ST_NB_RD:    state_next = nb_ok ? ST_NB_WAIT : ST_NB_CHECK;
      ST_NB_WAIT:  state_next = ST_NB_CHECK;
      ST_NB_CHECK: state_next = (dir == 2'd3) ? ST_POP : ST_NB_RD;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  assign nb_idx   = pix_idx(nb_r, nb_c);
  assign nb_probe = (state == ST_NB_CHECK) && nb_ok_q;
  assign nb_hit   = nb_probe && !vis_rdata && (pix_rdata == old_color);

  // Memory port control.
  always_comb begin
    pix_we = 1'b0; pix_addr = pix_idx(q_r, q_c); pix_wdata = fill_color;
    vis_we = 1'b0; vis_addr = clr_addr; vis_wdata = 1'b0;
    stk_we = 1'b0; stk_addr = sp[AW-1:0]; stk_wdata = {q_r, q_c};
    unique case (state)
      ST_SEED_RD: begin
        pix_we = (cmd_t'(in_cmd_q) == CMD_WRITE);
      end
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_wdata = (clr_addr == pix_idx(q_r, q_c));
        // The seed goes onto the stack at slot zero in the first sweep cycle.
        stk_addr  = '0;
        stk_we    = (clr_addr == '0);
      end
      ST_POP: stk_addr = sp[AW-1:0] - AW'(1);
      ST_POP_WAIT: begin
        pix_addr = pix_idx(stk_rdata[SW-1:CW], stk_rdata[CW-1:0]);
        pix_we   = 1'b1;
      end
      ST_NB_RD, ST_NB_WAIT: begin
        pix_addr = nb_idx;
        vis_addr = nb_idx;
      end
      ST_NB_CHECK: begin
        vis_addr  = nb_idx;
        vis_wdata = 1'b1;
        vis_we    = nb_hit;
        stk_wdata = {nb_r, nb_c};
        stk_we    = nb_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_q <= in_data.cmd;
      q_r      <= RW'(in_data.row);
      q_c      <= CW'(in_data.col);
      q_val    <= in_data.value;
      acc      <= '{read_value: '0, region_count: '0,
                    status: !in_range && (in_data.cmd != CMD_NONE)};
    end
    if (state == ST_DONE && (!out_valid || out_ready)) res <= acc;
    unique case (state)
      ST_SEED_WAIT: begin
        old_color <= pix_rdata;
        clr_addr  <= '0;
        count     <= '0;
        sp        <= SPW'(1);
        if (cmd_t'(in_cmd_q) == CMD_READ) acc.read_value <= 8'(pix_rdata);
      end
      ST_CLEAR: clr_addr <= clr_addr + AW'(1);
      ST_POP: begin
        if (sp != '0) sp <= sp - SPW'(1);
        else acc.region_count <= count;
      end
      ST_POP_WAIT: begin
        cur_r <= stk_rdata[SW-1:CW];
        cur_c <= stk_rdata[CW-1:0];
        count <= count + 13'd1;
        dir   <= 2'd0;
      end
      ST_NB_RD: nb_ok_q <= nb_ok;
      ST_NB_CHECK: begin
        dir <= dir + 2'd1;
        if (nb_hit) sp <= sp + SPW'(1);
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (sp <= SPW'(NPIX))) else $error("stack pointer past depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_addr == AW'(NPIX - 1)) |=> (state == ST_POP))
    else $error("clear sweep did not end");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> out_valid) else $error("lost result");
`endif
endmodule
